/* hw/rtl/cmdval_pkg.sv */
// ----------------------------------------------------------------------------
// Command line validator package
// Shared types, keyword table, character codes, status codes and the
// per-byte character-class helpers used by the validator.
// ----------------------------------------------------------------------------
package cmdval_pkg;

  // Sizing constants.
  localparam int MAX_PARAM_COUNT = 15;
  localparam int NICK_MAX_LEN    = 9;
  localparam int LEN_CAP         = NICK_MAX_LEN + 1;
  localparam int NUM_KW          = 12;
  localparam int KW_MAX_CHARS    = 8;
  localparam int PC_W            = $clog2(MAX_PARAM_COUNT + 1);
  localparam int TL_W            = $clog2(LEN_CAP + 1);
  localparam int CL_W            = 4;
  localparam int KEPT_PARAMS     = 3;

  // Parameter flag bit positions.
  localparam int F_NICK  = 0;
  localparam int F_CHAN  = 1;
  localparam int F_DIGIT = 2;
  localparam int F_STAR  = 3;
  localparam int F_SIGN  = 4;
  localparam int F_FULL  = 5;

  typedef logic [5:0]        pflags_t;
  typedef logic [NUM_KW-1:0] kw_mask_t;

  localparam pflags_t FLAGS_ALL = '1;

  // Parser phases.
  localparam logic [1:0] PH_CMD   = 2'd0;
  localparam logic [1:0] PH_GAP   = 2'd1;
  localparam logic [1:0] PH_PARAM = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  // Status codes.
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_CMD    = 4'd1;
  localparam logic [3:0] ST_UNKNOWN   = 4'd2;
  localparam logic [3:0] ST_NEED_PRM  = 4'd3;
  localparam logic [3:0] ST_BAD_NICK  = 4'd4;
  localparam logic [3:0] ST_BAD_FLAG  = 4'd5;
  localparam logic [3:0] ST_NO_RCPT   = 4'd6;
  localparam logic [3:0] ST_NO_TEXT   = 4'd7;
  localparam logic [3:0] ST_NO_TARGET = 4'd8;

  // Command indices.
  localparam logic [3:0] CMD_PASS    = 4'd0;
  localparam logic [3:0] CMD_NICK    = 4'd1;
  localparam logic [3:0] CMD_USER    = 4'd2;
  localparam logic [3:0] CMD_JOIN    = 4'd3;
  localparam logic [3:0] CMD_PART    = 4'd4;
  localparam logic [3:0] CMD_PRIVMSG = 4'd5;
  localparam logic [3:0] CMD_NOTICE  = 4'd6;
  localparam logic [3:0] CMD_QUIT    = 4'd7;
  localparam logic [3:0] CMD_MODE    = 4'd8;
  localparam logic [3:0] CMD_TOPIC   = 4'd9;
  localparam logic [3:0] CMD_INVITE  = 4'd10;
  localparam logic [3:0] CMD_KICK    = 4'd11;
  localparam logic [3:0] CMD_NONE    = 4'd12;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Keyword text, right-justified: the first character sits in the highest
  // used byte.
  localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [NUM_KW] = '{
    "PASS", "NICK", "USER", "JOIN", "PART", "PRIVMSG",
    "NOTICE", "QUIT", "MODE", "TOPIC", "INVITE", "KICK"
  };
  localparam logic [CL_W-1:0] KW_LEN [NUM_KW] = '{
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7, 4'd6, 4'd4, 4'd4, 4'd5, 4'd6, 4'd4
  };

  // True for A-Z, a-z, 0-9, '-' and '_'.
  function automatic logic name_char(input logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122) ||
           (c >= 8'd48 && c <= 8'd57) || c == CH_MINUS || c == CH_UNDER;
  endfunction

  // Flag update for one byte added to a parameter.
  function automatic pflags_t take_byte(input logic first, input pflags_t f_in,
                                        input logic [7:0] c);
    pflags_t f;
    f = f_in;
    if (first) begin
      if (c == CH_AMP || c == CH_HASH) f[F_NICK] = 1'b0;
      else f[F_CHAN] = 1'b0;
      if (c < 8'd48 || c > 8'd57) f[F_DIGIT] = 1'b0;
      if (c != CH_STAR) f[F_STAR] = 1'b0;
      if (c != CH_PLUS && c != CH_MINUS) f[F_SIGN] = 1'b0;
    end else begin
      if (!name_char(c)) f[F_CHAN] = 1'b0;
      f[F_DIGIT] = 1'b0;
    end
    if (c == CH_SPACE || c == CH_AT || c == CH_CR || c == CH_LF || c == CH_NUL) begin
      f[F_NICK] = 1'b0;
    end
    return f;
  endfunction

  // Final length checks when a parameter ends.
  function automatic pflags_t close_flags(input logic [TL_W-1:0] len,
                                          input pflags_t f_in);
    pflags_t f;
    f = f_in;
    if (len == '0) f = '0;
    if (len > TL_W'(NICK_MAX_LEN)) f[F_NICK] = 1'b0;
    if (len < TL_W'(2)) f[F_CHAN] = 1'b0;
    if (len != TL_W'(1)) f[F_DIGIT] = 1'b0;
    return f;
  endfunction

endpackage

/* hw/rtl/irc_command_line_validator_top.sv */
// ----------------------------------------------------------------------------
// Command line validator, top level
// A line's status passes the input register, then the result register.
// Throughput: one byte per cycle; a last byte waits for a free result slot.
// Reset: rst_n clears the parser state and both valid flags; the parser also
// returns to its reset state after every last byte.
// ----------------------------------------------------------------------------
// Parses a command line byte by byte, matches the command word against the
// keyword table, classifies parameters 0 to 2, and reports one status per line.
// ----------------------------------------------------------------------------
module irc_command_line_validator_top
  import cmdval_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_line_byte,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_status,
  output logic [3:0] out_command_index,
  output logic [3:0] out_param_count
);

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  // Parser state.
  logic [1:0]      phase_r, phase_nxt;
  kw_mask_t        kw_mask_r, kw_mask_nxt;
  logic [CL_W-1:0] cmd_len_r, cmd_len_nxt;
  logic [PC_W-1:0] params_r, params_nxt;
  logic [TL_W-1:0] tok_len_r, tok_len_nxt;
  pflags_t         tok_flags_r, tok_flags_nxt;
  pflags_t         kept_r [KEPT_PARAMS];
  pflags_t         kept_nxt [KEPT_PARAMS];

  // Result register.
  logic       out_vld_r;
  logic [3:0] status_r, status_nxt;
  logic [3:0] cmd_idx_r, cmd_idx_nxt;
  logic [3:0] pcount_r, pcount_nxt;

  logic out_free;
  logic s1_go;

  // Handshake: a last byte moves on only when the result slot is free.
  assign out_free = !out_vld_r || out_ready;
  assign s1_go    = in_vld_r && (!in_end_r || out_free);
  assign in_ready = !in_vld_r || s1_go;

  assign out_valid         = out_vld_r;
  assign out_status        = status_r;
  assign out_command_index = cmd_idx_r;
  assign out_param_count   = pcount_r;

  // Per-byte state update and end-of-line judgement.
  always_comb begin
    logic [1:0]      ph;
    logic [TL_W-1:0] tl;
    pflags_t         tf;
    logic [CL_W-1:0] cl;
    kw_mask_t        km;
    logic            do_take;
    logic            do_close;
    pflags_t         cf;
    logic [PC_W-1:0] pc;
    logic [3:0]      cmd;
    logic [2:0]      cidx;
    logic [7:0]      c;

    c       = in_byte_r;
    ph      = phase_r;
    tl      = tok_len_r;
    tf      = tok_flags_r;
    cl      = cmd_len_r;
    km      = kw_mask_r;
    pc      = params_r;
    do_take = 1'b0;
    do_close = 1'b0;
    cf      = '0;
    cidx    = '0;
    for (int i = 0; i < KEPT_PARAMS; i++) kept_nxt[i] = kept_r[i];

    unique case (phase_r)
      PH_CMD: begin
        if (c == CH_SPACE) begin
          ph = PH_GAP;
        end else begin
          // Drop every keyword whose character at this place differs.
          for (int k = 0; k < NUM_KW; k++) begin
            cidx = KW_LEN[k][2:0] - 3'd1 - cmd_len_r[2:0];
            if (cmd_len_r >= KW_LEN[k] || KW_TEXT[k][cidx*8 +: 8] != c) begin
              km[k] = 1'b0;
            end
          end
          if (cmd_len_r != '1) cl = cmd_len_r + CL_W'(1);
        end
      end
      PH_GAP: begin
        if (c != CH_SPACE && cmd_len_r != '0) begin
          tl = '0;
          tf = FLAGS_ALL;
          if (c == CH_COLON) begin
            ph = PH_TRAIL;
          end else begin
            ph      = PH_PARAM;
            do_take = 1'b1;
          end
        end
      end
      PH_PARAM: begin
        if (c == CH_SPACE) begin
          do_close = 1'b1;
          ph       = PH_GAP;
        end else begin
          do_take = 1'b1;
        end
      end
      PH_TRAIL: do_take = 1'b1;
      default: ;
    endcase

    // Add the byte to the current parameter.
    if (do_take) begin
      tf = take_byte(tl == '0, tf, c);
      if (tl < TL_W'(LEN_CAP)) tl = tl + TL_W'(1);
    end

    // The last byte also ends an open parameter.
    if (in_end_r && (ph == PH_PARAM || ph == PH_TRAIL)) do_close = 1'b1;

    // Close the parameter: keep flags of the first three, count it.
    if (do_close) begin
      cf = close_flags(tl, tf);
      for (int i = 0; i < KEPT_PARAMS; i++) begin
        if (pc == PC_W'(i)) kept_nxt[i] = cf;
      end
      if (pc < PC_W'(MAX_PARAM_COUNT)) pc = pc + PC_W'(1);
      tl = '0;
      tf = FLAGS_ALL;
    end

    // Pick the lowest keyword still matching at the full word length.
    cmd = CMD_NONE;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (km[k] && KW_LEN[k] == cl) cmd = 4'(k);
    end

    // Per-command checks in order.
    unique case (cmd) inside
      CMD_PASS, CMD_JOIN, CMD_PART: begin
        status_nxt = (pc < PC_W'(1)) ? ST_NEED_PRM : ST_OK;
      end
      CMD_NICK: begin
        if (pc < PC_W'(1)) status_nxt = ST_NEED_PRM;
        else status_nxt = kept_nxt[0][F_NICK] ? ST_OK : ST_BAD_NICK;
      end
      CMD_USER: begin
        if (pc < PC_W'(4)) status_nxt = ST_NEED_PRM;
        else if (!kept_nxt[0][F_NICK]) status_nxt = ST_BAD_NICK;
        else if (!kept_nxt[1][F_DIGIT]) status_nxt = ST_BAD_FLAG;
        else status_nxt = kept_nxt[2][F_STAR] ? ST_OK : ST_BAD_FLAG;
      end
      CMD_PRIVMSG: begin
        if (pc < PC_W'(1)) status_nxt = ST_NO_RCPT;
        else status_nxt = (pc == PC_W'(1)) ? ST_NO_TEXT : ST_OK;
      end
      CMD_NOTICE: begin
        if (pc < PC_W'(1)) status_nxt = ST_NO_RCPT;
        else if (pc == PC_W'(1) || !kept_nxt[1][F_FULL]) status_nxt = ST_NO_TEXT;
        else status_nxt = ST_OK;
      end
      CMD_QUIT: begin
        status_nxt = (pc != '0 && !kept_nxt[0][F_FULL]) ? ST_NO_TEXT : ST_OK;
      end
      CMD_MODE: begin
        if (pc < PC_W'(1)) status_nxt = ST_NEED_PRM;
        else if (pc > PC_W'(1) && !kept_nxt[1][F_SIGN]) status_nxt = ST_BAD_FLAG;
        else status_nxt = kept_nxt[0][F_CHAN] ? ST_OK : ST_NO_TARGET;
      end
      CMD_TOPIC: begin
        if (pc < PC_W'(1)) status_nxt = ST_NEED_PRM;
        else status_nxt = kept_nxt[0][F_CHAN] ? ST_OK : ST_NO_TARGET;
      end
      CMD_INVITE: begin
        if (pc < PC_W'(2)) status_nxt = ST_NEED_PRM;
        else if (!kept_nxt[0][F_NICK]) status_nxt = ST_NO_TARGET;
        else status_nxt = kept_nxt[1][F_CHAN] ? ST_OK : ST_NO_TARGET;
      end
      CMD_KICK: begin
        if (pc < PC_W'(2)) status_nxt = ST_NEED_PRM;
        else if (!kept_nxt[0][F_CHAN]) status_nxt = ST_NO_TARGET;
        else status_nxt = kept_nxt[1][F_NICK] ? ST_OK : ST_NO_TARGET;
      end
      default: status_nxt = ST_UNKNOWN;
    endcase

    cmd_idx_nxt = cmd;
    pcount_nxt  = (pc > PC_W'(15)) ? 4'd15 : 4'(pc);
    if (cl == '0) begin
      status_nxt  = ST_NO_CMD;
      cmd_idx_nxt = CMD_NONE;
      pcount_nxt  = 4'd0;
    end

    // After the last byte every field goes back to its reset value.
    if (in_end_r) begin
      phase_nxt     = PH_CMD;
      kw_mask_nxt   = '1;
      cmd_len_nxt   = '0;
      params_nxt    = '0;
      tok_len_nxt   = '0;
      tok_flags_nxt = FLAGS_ALL;
      for (int i = 0; i < KEPT_PARAMS; i++) kept_nxt[i] = '0;
    end else begin
      phase_nxt     = ph;
      kw_mask_nxt   = km;
      cmd_len_nxt   = cl;
      params_nxt    = pc;
      tok_len_nxt   = tl;
      tok_flags_nxt = tf;
    end
  end

  // Input register: capture a byte on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      in_byte_r <= in_line_byte;
      in_end_r  <= in_line_end;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CMD;
      kw_mask_r   <= '1;
      cmd_len_r   <= '0;
      params_r    <= '0;
      tok_len_r   <= '0;
      tok_flags_r <= FLAGS_ALL;
      for (int i = 0; i < KEPT_PARAMS; i++) kept_r[i] <= '0;
    end else if (s1_go) begin
      phase_r     <= phase_nxt;
      kw_mask_r   <= kw_mask_nxt;
      cmd_len_r   <= cmd_len_nxt;
      params_r    <= params_nxt;
      tok_len_r   <= tok_len_nxt;
      tok_flags_r <= tok_flags_nxt;
      for (int i = 0; i < KEPT_PARAMS; i++) kept_r[i] <= kept_nxt[i];
    end
  end

  // Result register: loaded by a last byte, emptied by an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && in_end_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
    if (s1_go && in_end_r) begin
      status_r  <= status_nxt;
      cmd_idx_r <= cmd_idx_nxt;
      pcount_r  <= pcount_nxt;
    end
  end

endmodule

/* sim/irc_command_line_validator_top_test.sv */
// ----------------------------------------------------------------------------
// Command line validator testbench
// Sends command lines one byte per transfer and tracks the parser in a
// behavioral model of its own. Each line's status, command index and
// parameter count are compared against that prediction. Directed lines cover
// every command, some lines accepted and some with errors, then random lines
// follow. Both the byte sender and the status receiver idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module irc_command_line_validator_top_test;
  import cmdval_pkg::*;

  // ASCII anchors for the character classes.
  localparam logic [7:0] CHR_DIGIT0  = 8'h30;
  localparam logic [7:0] CHR_DIGIT9  = 8'h39;
  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [3:0] WORD_LEN_CAP = 4'hF;

  // Shapes of generated parameters.
  typedef enum int {K_NICK, K_CHAN, K_DIGIT, K_STAR, K_SIGN, K_JUNK, K_TRAIL} param_kind_t;

  typedef struct packed {
    logic [3:0] status;
    logic [3:0] command;
    logic [3:0] count;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_line_byte = 8'h00;
  logic       in_line_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_status;
  logic [3:0] out_command_index;
  logic [3:0] out_param_count;

  // Line parser state as tracked by the testbench.
  logic [1:0]  line_phase;
  logic [11:0] word_mask;
  logic [3:0]  word_len;
  logic [3:0]  param_total;
  logic [3:0]  token_len;
  pflags_t     token_class;
  pflags_t     kept_class [3];

  verdict_t   pending_verdicts[$];
  verdict_t   oldest_verdict;
  logic [7:0] line_buf[$];
  bit         failed = 1'b0;
  int         bytes_sent = 0;
  int         lines_sent = 0;
  int         burst_left = 0;
  int         ready_mode = 0;
  int         ready_left = 0;

  irc_command_line_validator_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_line_byte     (in_line_byte),
    .in_line_end      (in_line_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_command_index(out_command_index),
    .out_param_count  (out_param_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Keyword table, text right-justified like a string literal.
  function automatic logic [55:0] keyword_text(input logic [3:0] k);
    case (k)
      CMD_PASS:    return "PASS";
      CMD_NICK:    return "NICK";
      CMD_USER:    return "USER";
      CMD_JOIN:    return "JOIN";
      CMD_PART:    return "PART";
      CMD_PRIVMSG: return "PRIVMSG";
      CMD_NOTICE:  return "NOTICE";
      CMD_QUIT:    return "QUIT";
      CMD_MODE:    return "MODE";
      CMD_TOPIC:   return "TOPIC";
      CMD_INVITE:  return "INVITE";
      default:     return "KICK";
    endcase
  endfunction

  function automatic logic [3:0] keyword_len(input logic [3:0] k);
    case (k)
      CMD_PRIVMSG:           return 4'd7;
      CMD_NOTICE, CMD_INVITE: return 4'd6;
      CMD_TOPIC:             return 4'd5;
      default:               return 4'd4;
    endcase
  endfunction

  function automatic logic [7:0] keyword_char(input logic [3:0] k, input logic [3:0] pos);
    logic [55:0] text;
    text = keyword_text(k);
    return text[8 * (keyword_len(k) - 1 - pos) +: 8];
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) || (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) ||
           (c >= CHR_DIGIT0 && c <= CHR_DIGIT9) || c == CH_MINUS || c == CH_UNDER;
  endfunction

  task automatic restart_token();
    token_len = '0;
    token_class = FLAGS_ALL;
  endtask

  task automatic clear_line_state();
    line_phase = PH_CMD;
    word_mask = '1;
    word_len = '0;
    param_total = '0;
    restart_token();
    kept_class[0] = '0;
    kept_class[1] = '0;
    kept_class[2] = '0;
  endtask

  // Narrows the keyword candidates by one byte of the command word.
  task automatic match_word_byte(input logic [7:0] c);
    for (int k = 0; k < NUM_KW; k++) begin
      if (word_len >= keyword_len(4'(k))) word_mask[k] = 1'b0;
      else if (keyword_char(4'(k), word_len) != c) word_mask[k] = 1'b0;
    end
    if (word_len != WORD_LEN_CAP) word_len = word_len + 1'b1;
  endtask

  // Updates the running character classes of the current parameter.
  task automatic classify_param_byte(input logic [7:0] c);
    pflags_t f;
    f = token_class;
    if (token_len == '0) begin
      if (c == CH_AMP || c == CH_HASH) f[F_NICK] = 1'b0;
      else f[F_CHAN] = 1'b0;
      if (c < CHR_DIGIT0 || c > CHR_DIGIT9) f[F_DIGIT] = 1'b0;
      if (c != CH_STAR) f[F_STAR] = 1'b0;
      if (c != CH_PLUS && c != CH_MINUS) f[F_SIGN] = 1'b0;
    end else begin
      if (!is_word_char(c)) f[F_CHAN] = 1'b0;
      f[F_DIGIT] = 1'b0;
    end
    if (c == CH_SPACE || c == CH_AT || c == CH_CR || c == CH_LF || c == CH_NUL) begin
      f[F_NICK] = 1'b0;
    end
    token_class = f;
    if (token_len < LEN_CAP) token_len = token_len + 1'b1;
  endtask

  // Applies the length rules and stores the classes of the first three params.
  task automatic seal_param();
    pflags_t f;
    f = token_class;
    if (token_len == '0) f = '0;
    if (token_len > NICK_MAX_LEN) f[F_NICK] = 1'b0;
    if (token_len < 2) f[F_CHAN] = 1'b0;
    if (token_len != 1) f[F_DIGIT] = 1'b0;
    if (param_total < KEPT_PARAMS) kept_class[param_total] = f;
    if (param_total < MAX_PARAM_COUNT) param_total = param_total + 1'b1;
    restart_token();
  endtask

  // Per-command checks in their defined order.
  function automatic logic [3:0] grade_line(input logic [3:0] cmd, input logic [3:0] n);
    pflags_t f0;
    pflags_t f1;
    pflags_t f2;
    f0 = kept_class[0];
    f1 = kept_class[1];
    f2 = kept_class[2];
    case (cmd)
      CMD_PASS, CMD_JOIN, CMD_PART: return (n < 1) ? ST_NEED_PRM : ST_OK;
      CMD_NICK: begin
        if (n < 1) return ST_NEED_PRM;
        return f0[F_NICK] ? ST_OK : ST_BAD_NICK;
      end
      CMD_USER: begin
        if (n < 4) return ST_NEED_PRM;
        if (!f0[F_NICK]) return ST_BAD_NICK;
        if (!f1[F_DIGIT]) return ST_BAD_FLAG;
        return f2[F_STAR] ? ST_OK : ST_BAD_FLAG;
      end
      CMD_PRIVMSG: begin
        if (n < 1) return ST_NO_RCPT;
        return (n == 1) ? ST_NO_TEXT : ST_OK;
      end
      CMD_NOTICE: begin
        if (n < 1) return ST_NO_RCPT;
        return (n == 1 || !f1[F_FULL]) ? ST_NO_TEXT : ST_OK;
      end
      CMD_QUIT: return (n > 0 && !f0[F_FULL]) ? ST_NO_TEXT : ST_OK;
      CMD_MODE: begin
        if (n < 1) return ST_NEED_PRM;
        if (n > 1 && !f1[F_SIGN]) return ST_BAD_FLAG;
        return f0[F_CHAN] ? ST_OK : ST_NO_TARGET;
      end
      CMD_TOPIC: begin
        if (n < 1) return ST_NEED_PRM;
        return f0[F_CHAN] ? ST_OK : ST_NO_TARGET;
      end
      CMD_INVITE: begin
        if (n < 2) return ST_NEED_PRM;
        if (!f0[F_NICK]) return ST_NO_TARGET;
        return f1[F_CHAN] ? ST_OK : ST_NO_TARGET;
      end
      CMD_KICK: begin
        if (n < 2) return ST_NEED_PRM;
        if (!f0[F_CHAN]) return ST_NO_TARGET;
        return f1[F_NICK] ? ST_OK : ST_NO_TARGET;
      end
      default: return ST_UNKNOWN;
    endcase
  endfunction

  // Advances the line state by one transferred byte; the last byte of a line
  // queues the status that the block should report for it.
  task automatic track_line_byte(input logic [7:0] c, input logic last);
    verdict_t v;
    case (line_phase)
      PH_CMD: begin
        if (c == CH_SPACE) line_phase = PH_GAP;
        else match_word_byte(c);
      end
      PH_GAP: begin
        if (c != CH_SPACE && word_len != '0) begin
          restart_token();
          if (c == CH_COLON) begin
            line_phase = PH_TRAIL;
          end else begin
            line_phase = PH_PARAM;
            classify_param_byte(c);
          end
        end
      end
      PH_PARAM: begin
        if (c == CH_SPACE) begin
          seal_param();
          line_phase = PH_GAP;
        end else begin
          classify_param_byte(c);
        end
      end
      default: classify_param_byte(c);
    endcase
    if (last) begin
      if (line_phase == PH_PARAM || line_phase == PH_TRAIL) seal_param();
      v.command = CMD_NONE;
      v.count = param_total;
      if (word_len == '0) begin
        v.status = ST_NO_CMD;
        v.count = '0;
      end else begin
        // Lowest matching index wins.
        for (int k = NUM_KW - 1; k >= 0; k--) begin
          if (word_mask[k] && keyword_len(4'(k)) == word_len) v.command = 4'(k);
        end
        v.status = grade_line(v.command, param_total);
      end
      pending_verdicts.insert(pending_verdicts.size(), v);
      clear_line_state();
    end
  endtask

  // Sends one byte, with a random idle gap at the start of each burst.
  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(100, 300);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_line_byte <= c;
    in_line_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_line_byte(c, last);
    bytes_sent++;
  endtask

  task automatic append_byte(input logic [7:0] c);
    line_buf.insert(line_buf.size(), c);
  endtask

  task automatic append_text(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i], i == line_buf.size() - 1);
    line_buf.delete();
    lines_sent++;
  endtask

  function automatic logic [7:0] random_word_char();
    int r;
    r = $urandom_range(0, 63);
    if (r < 26) return CHR_UPPER_A + 8'(r);
    if (r < 52) return CHR_LOWER_A + 8'(r - 26);
    if (r < 62) return CHR_DIGIT0 + 8'(r - 52);
    return (r == 62) ? CH_MINUS : CH_UNDER;
  endfunction

  function automatic logic [7:0] random_nonspace_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == CH_SPACE) ? CH_AT : b;
  endfunction

  // Parameter shapes that each command expects in a given position.
  function automatic param_kind_t usual_kind(input logic [3:0] cmd, input int idx);
    case (cmd)
      CMD_USER: begin
        case (idx)
          0: return K_NICK;
          1: return K_DIGIT;
          2: return K_STAR;
          default: return K_TRAIL;
        endcase
      end
      CMD_PRIVMSG, CMD_NOTICE: begin
        if (idx == 0) return ($urandom_range(0, 1) != 0) ? K_NICK : K_CHAN;
        return K_TRAIL;
      end
      CMD_MODE: return (idx == 0) ? K_CHAN : K_SIGN;
      CMD_TOPIC: return (idx == 0) ? K_CHAN : K_TRAIL;
      CMD_INVITE: return (idx == 0) ? K_NICK : K_CHAN;
      CMD_KICK: begin
        case (idx)
          0: return K_CHAN;
          1: return K_NICK;
          default: return K_TRAIL;
        endcase
      end
      CMD_JOIN, CMD_PART: return K_CHAN;
      CMD_PASS: return K_JUNK;
      CMD_QUIT: return K_TRAIL;
      default: return K_NICK;
    endcase
  endfunction

  task automatic append_param(input param_kind_t kind);
    int n;
    case (kind)
      K_NICK: begin
        n = $urandom_range(1, 11);
        repeat (n) append_byte(($urandom_range(0, 6) != 0) ? random_word_char() :
                               random_nonspace_byte());
      end
      K_CHAN: begin
        append_byte(($urandom_range(0, 1) != 0) ? CH_HASH : CH_AMP);
        n = $urandom_range(0, 10);
        repeat (n) append_byte(($urandom_range(0, 9) != 0) ? random_word_char() :
                               random_nonspace_byte());
      end
      K_DIGIT: begin
        append_byte(CHR_DIGIT0 + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 9) == 0) append_byte(random_word_char());
      end
      K_STAR: begin
        append_byte(CH_STAR);
        if ($urandom_range(0, 4) == 0) append_byte(random_word_char());
      end
      K_SIGN: begin
        append_byte(($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
        n = $urandom_range(0, 4);
        repeat (n) append_byte(random_word_char());
      end
      K_JUNK: begin
        n = $urandom_range(1, 12);
        repeat (n) append_byte(random_nonspace_byte());
      end
      default: begin
        // Trailing text may hold spaces and any other byte.
        append_byte(CH_COLON);
        n = $urandom_range(0, 15);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0, 1:    append_byte(CH_SPACE);
            2:       append_byte(8'($urandom_range(0, 255)));
            default: append_byte(random_word_char());
          endcase
        end
      end
    endcase
  endtask

  // Builds one random line: mostly a command word with shaped parameters,
  // sometimes a word that only resembles a keyword, sometimes pure noise.
  task automatic build_random_line();
    int mode;
    int n;
    int count;
    int idx;
    bit shaped;
    bit done;
    logic [3:0] k;
    param_kind_t kind;
    mode = $urandom_range(0, 99);
    if (mode < 5) begin
      append_byte(CH_SPACE);
      n = $urandom_range(0, 12);
      repeat (n) append_byte(($urandom_range(0, 3) == 0) ? CH_SPACE : random_word_char());
    end else if (mode < 10) begin
      n = $urandom_range(1, 20);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
    end else begin
      k = 4'($urandom_range(0, NUM_KW - 1));
      mode = $urandom_range(0, 99);
      if (mode < 75) begin
        for (int i = 0; i < keyword_len(k); i++) append_byte(keyword_char(k, 4'(i)));
      end else if (mode < 82) begin
        for (int i = 0; i < keyword_len(k); i++) begin
          append_byte(keyword_char(k, 4'(i)) + CASE_OFFSET);
        end
      end else if (mode < 88) begin
        for (int i = 0; i < keyword_len(k) - 1; i++) append_byte(keyword_char(k, 4'(i)));
      end else if (mode < 94) begin
        for (int i = 0; i < keyword_len(k); i++) append_byte(keyword_char(k, 4'(i)));
        append_byte(random_word_char());
      end else begin
        n = $urandom_range(1, 18);
        repeat (n) append_byte(random_word_char());
      end
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(6, 18) : $urandom_range(0, 5);
      shaped = ($urandom_range(0, 9) < 6);
      done = 1'b0;
      idx = 0;
      while (idx < count && !done) begin
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n) append_byte(CH_SPACE);
        kind = shaped ? usual_kind(k, idx) : param_kind_t'($urandom_range(0, 6));
        append_param(kind);
        done = (kind == K_TRAIL);
        idx++;
      end
      if (!done && $urandom_range(0, 19) == 0) begin
        append_byte(CH_SPACE);
        append_byte(CH_COLON);
      end else if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) append_byte(CH_SPACE);
      end
    end
  endtask

  // Every command at least once, some lines accepted and some with errors.
  task automatic test_command_checks();
    append_text("PASS secret");             send_line();
    append_text("NICK");                    send_line();
    append_text("NICK bad@nick");           send_line();
    append_text("NICK goodnick");           send_line();
    append_text("USER guest 0 * :Real Name"); send_line();
    append_text("USER guest x * :r");       send_line();
    append_text("USER guest 5 + :r");       send_line();
    append_text("JOIN #chan");              send_line();
    append_text("PART");                    send_line();
    append_text("PRIVMSG");                 send_line();
    append_text("PRIVMSG bob");             send_line();
    append_text("PRIVMSG bob :hi there");   send_line();
    append_text("NOTICE bob :");            send_line();
    append_text("QUIT :");                  send_line();
    append_text("QUIT");                    send_line();
    append_text("MODE #c x");               send_line();
    append_text("MODE nick +i");            send_line();
    append_text("TOPIC #a-b_c :t");         send_line();
    append_text("INVITE bob #chan");        send_line();
    append_text("KICK #chan verylongnick"); send_line();
  endtask

  // Lines with no command, unknown words, odd spacing and byte extremes.
  task automatic test_special_lines();
    append_text(" NICK x");                 send_line();
    append_text("HELLO a b");               send_line();
    append_text("JOIN #c   ");              send_line();
    append_text("PASS :");                  send_line();
    append_text("PRIVMSGX bob :x");         send_line();
    append_text("NICK a");
    append_byte(CH_NUL);
    send_line();
    append_text("NOTICE #x :");
    append_byte(8'hFF);
    append_byte(8'h80);
    send_line();
    append_byte(8'hFF);                     send_line();
    append_text("JOIN a b c d e f g h i j k l m n o p q r"); send_line();
  endtask

  task automatic test_random_lines();
    while (bytes_sent < 1000 || lines_sent < 90) begin
      build_random_line();
      send_line();
    end
  endtask

  // The receiver stalls in phases: always ready, mostly ready, mostly
  // stalled, and a fixed duty pattern.
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_left <= $urandom_range(20, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= ((ready_left % 16) < 5);
    endcase
  end

  task automatic report_field(input string field, input logic [3:0] want,
                              input logic [3:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failed = 1'b1;
    end
  endtask

  // Compares each result transfer against the oldest predicted status.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d command %0d count %0d",
                 $time, out_status, out_command_index, out_param_count);
        failed = 1'b1;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        report_field("status", oldest_verdict.status, out_status);
        report_field("command index", oldest_verdict.command, out_command_index);
        report_field("param count", oldest_verdict.count, out_param_count);
      end
    end
  end

  initial begin
    clear_line_state();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_command_checks();
    test_special_lines();
    test_random_lines();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
